// ===== hdl/utf8_to_utf16_transcoder_assert.svh =====
// Assertion macros shared by the queue and output-side modules.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utt_pkg.sv =====
// Types and constants of the UTF-8 to UTF-16 transcoder.
package utt_pkg;

  // One input beat: a raw UTF-8 byte and its end-of-string mark.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       string_end;
  } utf8_beat_t;

  // One output beat: a UTF-16 code unit or a status result.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        bad_input;
    logic        end_of_string;
    logic        last;
  } utf16_beat_t;

  // A classified byte waiting for the output side: one or two results.
  typedef struct packed {
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    logic        pair;
    logic        has_unit;
    logic        bad;
    logic        eos;
  } utt_job_t;

  // Lead byte class limits.
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;

  // Code point limits.
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE = 21'h010000;

  // Surrogate pair bases.
  localparam logic [15:0] UNIT_HI_BASE = 16'hD800;
  localparam logic [15:0] UNIT_LO_BASE = 16'hDC00;

endpackage

// ===== hdl/utt_front.sv =====
// Front end: accepts UTF-8 bytes, tracks the sequence state and classifies each byte.
module utt_front import utt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  utf8_beat_t byte_beat,
  output logic       push,
  output utt_job_t   push_job,
  input  logic       room
);

  logic [20:0] pcp, pcp_next;
  logic [1:0]  rem, rem_next;
  logic        disc, disc_next;

  logic        accept;
  logic        emit;
  logic        err;
  logic        done;
  logic [20:0] cp;
  logic [20:0] shifted;
  logic [20:0] ofs;
  logic [7:0]  b;
  logic        eos;

  assign byte_ready = room;
  assign accept     = byte_valid && room;
  assign push       = accept && emit;

  // Decode one byte against the current sequence state.
  always_comb begin
    b         = byte_beat.byte_in;
    eos       = byte_beat.string_end;
    pcp_next  = pcp;
    rem_next  = rem;
    disc_next = disc;
    err       = 1'b0;
    done      = 1'b0;
    cp        = '0;
    emit      = 1'b0;
    push_job  = '0;
    ofs       = '0;
    shifted   = {pcp[14:0], b[5:0]};
    if (disc) begin
      // After an error only the string's last byte gives a marker.
      if (eos) begin
        disc_next    = 1'b0;
        pcp_next     = '0;
        rem_next     = '0;
        emit         = 1'b1;
        push_job.eos = 1'b1;
      end
    end else begin
      if (rem == 2'd0) begin
        if (b <= ASCII_MAX) begin
          cp   = {13'd0, b};
          done = 1'b1;
        end else if (b <= CONT_MAX) begin
          err = 1'b1;
        end else if (b <= LEAD2_MAX) begin
          pcp_next = {16'd0, b[4:0]};
          rem_next = 2'd1;
        end else if (b <= LEAD3_MAX) begin
          pcp_next = {17'd0, b[3:0]};
          rem_next = 2'd2;
        end else if (b <= LEAD4_MAX) begin
          pcp_next = {18'd0, b[2:0]};
          rem_next = 2'd3;
        end else begin
          err = 1'b1;
        end
      end else begin
        if (b[7:6] != 2'b10) begin
          err = 1'b1;
        end else begin
          pcp_next = shifted;
          rem_next = rem - 2'd1;
          if (rem == 2'd1) begin
            done = 1'b1;
            cp   = shifted;
          end
        end
      end

      // A string that stops mid-sequence, or a value that is no scalar.
      if (!err && !done && eos) begin
        err = 1'b1;
      end
      if (done && ((cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX)) begin
        err = 1'b1;
      end

      if (err) begin
        pcp_next     = '0;
        rem_next     = '0;
        disc_next    = !eos;
        emit         = 1'b1;
        push_job.bad = 1'b1;
        push_job.eos = eos;
      end else if (done) begin
        pcp_next          = '0;
        rem_next          = '0;
        emit              = 1'b1;
        push_job.has_unit = 1'b1;
        push_job.eos      = eos;
        if (cp <= BMP_MAX) begin
          push_job.unit_a = cp[15:0];
        end else begin
          ofs             = cp - SUPP_BASE;
          push_job.pair   = 1'b1;
          push_job.unit_a = UNIT_HI_BASE | {6'd0, ofs[19:10]};
          push_job.unit_b = UNIT_LO_BASE | {6'd0, ofs[9:0]};
        end
      end else if (eos) begin
        // Not reachable: a last byte that completes nothing is an error.
        emit = 1'b0;
      end
    end
  end

  // Sequence state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      pcp  <= '0;
      rem  <= '0;
      disc <= 1'b0;
    end else if (accept) begin
      pcp  <= pcp_next;
      rem  <= rem_next;
      disc <= disc_next;
    end
  end

endmodule

// ===== hdl/utt_queue.sv =====
// Short queue of classified jobs between the front end and the output side.
module utt_queue import utt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  utt_job_t push_job,
  output logic     room,
  input  logic     pop,
  output logic     job_valid,
  output utt_job_t head_job
);

`include "utf8_to_utf16_transcoder_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utt_job_t        entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign room      = (count != CW'(DEPTH));
  assign job_valid = (count != '0);
  assign head_job  = entries[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `UTT_ASSERT_NOW(a_push_has_room, push, room, "job pushed into a full queue")
  `UTT_ASSERT_NOW(a_pop_not_empty, pop, job_valid, "job popped from an empty queue")
  `UTT_ASSERT_NEXT(a_count_grows, push && !pop, count == $past(count) + CW'(1), "count lost a push")

endmodule

// ===== hdl/utt_back.sv =====
// Output side: turns each job into one or two result beats behind an output register.
module utt_back import utt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  utt_job_t    head_job,
  output logic        pop,
  output logic        utf16_valid,
  input  logic        utf16_ready,
  output utf16_beat_t utf16_beat
);

`include "utf8_to_utf16_transcoder_assert.svh"

  logic        out_valid;
  utf16_beat_t out_beat;
  logic        pend;
  logic [15:0] pend_unit;
  logic        pend_eos;
  logic        load_ok;

  assign load_ok     = !out_valid || utf16_ready;
  assign pop         = load_ok && !pend && job_valid;
  assign utf16_valid = out_valid;
  assign utf16_beat  = out_beat;

  // Output register and the second half of a surrogate pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load_ok) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (job_valid) begin
        out_valid <= 1'b1;
        pend      <= head_job.pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the output beat.
  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (pend) begin
        out_beat.code_unit     <= pend_unit;
        out_beat.has_unit      <= 1'b1;
        out_beat.bad_input     <= 1'b0;
        out_beat.end_of_string <= pend_eos;
        out_beat.last          <= 1'b1;
      end else if (job_valid) begin
        out_beat.code_unit     <= head_job.unit_a;
        out_beat.has_unit      <= head_job.has_unit;
        out_beat.bad_input     <= head_job.bad;
        out_beat.end_of_string <= head_job.eos && !head_job.pair;
        out_beat.last          <= !head_job.pair;
        pend_unit              <= head_job.unit_b;
        pend_eos               <= head_job.eos;
      end
    end
  end

  `UTT_ASSERT_NOW(a_pend_behind_out, pend, out_valid, "pair half pending with no beat shown")
  `UTT_ASSERT_NOW(a_no_pop_while_pend, pend, !pop, "job popped while a pair half waits")
  `UTT_ASSERT_NEXT(a_out_held, out_valid && !utf16_ready, utf16_valid && $stable(utf16_beat), "stalled beat changed")

endmodule

// ===== hdl/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
//
//   channel  | role    | handshake                 | payload
//   utf8     | in      | utf8_valid / utf8_ready   | utf8_beat_t  (byte_in, string_end)
//   utf16    | out     | utf16_valid / utf16_ready | utf16_beat_t (code_unit, flags)
//
// One byte is taken per cycle while the job queue has room; its results pass
// through the queue and the output register. A surrogate pair gives two beats from
// the single output register; the job queue (QUEUE_DEPTH entries) absorbs this.
// utf8_ready drops only while the job queue is full.
// Synchronous active-high reset clears the sequence state, the queue and the
// output register.
module utf8_to_utf16_transcoder import utt_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        utf8_valid,
  output logic        utf8_ready,
  input  utf8_beat_t  utf8_beat,
  output logic        utf16_valid,
  input  logic        utf16_ready,
  output utf16_beat_t utf16_beat
);

  logic     push;
  utt_job_t push_job;
  logic     room;
  logic     pop;
  logic     job_valid;
  utt_job_t head_job;

  // Byte decoding and classification.
  utt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (utf8_valid),
    .byte_ready (utf8_ready),
    .byte_beat  (utf8_beat),
    .push       (push),
    .push_job   (push_job),
    .room       (room)
  );

  // Job queue between decoding and output.
  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .room      (room),
    .pop       (pop),
    .job_valid (job_valid),
    .head_job  (head_job)
  );

  // Result beats.
  utt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .head_job    (head_job),
    .pop         (pop),
    .utf16_valid (utf16_valid),
    .utf16_ready (utf16_ready),
    .utf16_beat  (utf16_beat)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
module tb import utt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 12;
  localparam int HOLD_AFTER  = 40;
  localparam int HOLD_CYCLES = 250;

  // Ways a generated string can be broken.
  typedef enum int {
    FAULT_NONE,
    FAULT_STRAY,
    FAULT_LEAD,
    FAULT_CONT,
    FAULT_SURR,
    FAULT_BIG,
    FAULT_CUT,
    FAULT_NOISE
  } fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        utf8_valid = 1'b0;
  logic        utf8_ready;
  utf8_beat_t  utf8_beat = '0;
  logic        utf16_valid;
  logic        utf16_ready = 1'b0;
  utf16_beat_t utf16_beat;

  utf8_beat_t  pending_bytes[$];
  utf16_beat_t expected_units[$];
  logic [7:0]  str_bytes[$];

  // Decoder state mirrored from the block.
  logic [20:0] acc_point = '0;
  logic [1:0]  conts_due = '0;
  logic        dropping = 1'b0;

  int errors = 0;
  int cycles = 0;
  int in_idle_pct = 32;
  int out_idle_pct = 32;
  int units_seen = 0;
  int hold_left = 0;
  bit held = 1'b0;

  utf8_to_utf16_transcoder uut (
    .clk         (clk),
    .rst         (rst),
    .utf8_valid  (utf8_valid),
    .utf8_ready  (utf8_ready),
    .utf8_beat   (utf8_beat),
    .utf16_valid (utf16_valid),
    .utf16_ready (utf16_ready),
    .utf16_beat  (utf16_beat)
  );

  always #4 clk = ~clk;

  // Decode one accepted byte and queue the code units it should produce.
  task automatic transcode_byte(input utf8_beat_t b);
    logic [20:0] point;
    logic [20:0] offs;
    logic        done;
    logic        bad;
    utf16_beat_t r;
    point = '0;
    done = 1'b0;
    bad = 1'b0;
    r = '0;
    // After an error only the end of the string matters.
    if (dropping) begin
      if (b.string_end) begin
        dropping = 1'b0;
        r.end_of_string = 1'b1;
        r.last = 1'b1;
        expected_units.insert(expected_units.size(), r);
      end
      return;
    end
    if (conts_due == 2'd0) begin
      if (b.byte_in <= ASCII_MAX) begin
        point = {13'b0, b.byte_in};
        done = 1'b1;
      end else if (b.byte_in <= CONT_MAX) begin
        bad = 1'b1;
      end else if (b.byte_in <= LEAD2_MAX) begin
        acc_point = {16'b0, b.byte_in[4:0]};
        conts_due = 2'd1;
      end else if (b.byte_in <= LEAD3_MAX) begin
        acc_point = {17'b0, b.byte_in[3:0]};
        conts_due = 2'd2;
      end else if (b.byte_in <= LEAD4_MAX) begin
        acc_point = {18'b0, b.byte_in[2:0]};
        conts_due = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end else if (b.byte_in[7:6] != 2'b10) begin
      bad = 1'b1;
    end else begin
      acc_point = {acc_point[14:0], b.byte_in[5:0]};
      conts_due = conts_due - 2'd1;
      if (conts_due == 2'd0) begin
        point = acc_point;
        done = 1'b1;
      end
    end
    // A string must not end inside a sequence, and the value must be a scalar.
    if (!bad && !done && b.string_end)
      bad = 1'b1;
    if (done && ((point >= SURR_LO && point <= SURR_HI) || point > CP_MAX))
      bad = 1'b1;
    if (bad) begin
      acc_point = '0;
      conts_due = '0;
      dropping = !b.string_end;
      r.bad_input = 1'b1;
      r.end_of_string = b.string_end;
      r.last = 1'b1;
      expected_units.insert(expected_units.size(), r);
    end else if (done) begin
      acc_point = '0;
      conts_due = '0;
      r.has_unit = 1'b1;
      if (point <= BMP_MAX) begin
        r.code_unit = point[15:0];
        r.end_of_string = b.string_end;
        r.last = 1'b1;
        expected_units.insert(expected_units.size(), r);
      end else begin
        // Supplementary plane: high surrogate first, then low surrogate.
        offs = point - SUPP_BASE;
        r.code_unit = {6'b0, offs[19:10]} + UNIT_HI_BASE;
        expected_units.insert(expected_units.size(), r);
        r.code_unit = {6'b0, offs[9:0]} + UNIT_LO_BASE;
        r.end_of_string = b.string_end;
        r.last = 1'b1;
        expected_units.insert(expected_units.size(), r);
      end
    end
  endtask

  // Append the UTF-8 form of a code point, using len bytes (longer is overlong).
  task automatic encode_point(input logic [20:0] point, input int len);
    case (len)
      1: str_bytes.insert(str_bytes.size(), point[7:0]);
      2: begin
        str_bytes.insert(str_bytes.size(), {3'b110, point[10:6]});
        str_bytes.insert(str_bytes.size(), {2'b10, point[5:0]});
      end
      3: begin
        str_bytes.insert(str_bytes.size(), {4'b1110, point[15:12]});
        str_bytes.insert(str_bytes.size(), {2'b10, point[11:6]});
        str_bytes.insert(str_bytes.size(), {2'b10, point[5:0]});
      end
      default: begin
        str_bytes.insert(str_bytes.size(), {5'b11110, point[20:18]});
        str_bytes.insert(str_bytes.size(), {2'b10, point[17:12]});
        str_bytes.insert(str_bytes.size(), {2'b10, point[11:6]});
        str_bytes.insert(str_bytes.size(), {2'b10, point[5:0]});
      end
    endcase
  endtask

  // Queue one string of byte beats, mostly well formed; returns its length.
  task automatic add_string(output int count);
    int     chars;
    int     fault_at;
    int     pick;
    int     len;
    int     bad_byte;
    fault_t fault;
    logic [20:0] point;
    str_bytes.delete();
    chars = $urandom_range(1, 6);
    fault_at = $urandom_range(0, chars - 1);
    fault = ($urandom_range(99) < 25) ? fault_t'($urandom_range(FAULT_STRAY, FAULT_NOISE))
                                      : FAULT_NONE;
    for (int i = 0; i < chars; i++) begin
      // Broken bytes go in on a character boundary.
      if (i == fault_at) begin
        case (fault)
          FAULT_STRAY: str_bytes.insert(str_bytes.size(), 8'($urandom_range(8'h80, 8'hBF)));
          FAULT_LEAD:  str_bytes.insert(str_bytes.size(), 8'($urandom_range(8'hF8, 8'hFF)));
          FAULT_CONT: begin
            bad_byte = $urandom_range(0, 191);
            if (bad_byte >= 128)
              bad_byte += 64;
            str_bytes.insert(str_bytes.size(), 8'($urandom_range(8'hC0, 8'hF7)));
            str_bytes.insert(str_bytes.size(), 8'(bad_byte));
          end
          FAULT_SURR: encode_point(21'($urandom_range(SURR_LO, SURR_HI)), 3);
          FAULT_BIG:  encode_point(21'($urandom_range(CP_MAX + 1, 21'h1FFFFF)), 4);
          default: ;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        point = 21'($urandom_range(0, 8'h7F));
        len = 1;
      end else if (pick < 60) begin
        point = 21'($urandom_range(12'h080, 12'h7FF));
        len = 2;
      end else if (pick < 80) begin
        point = $urandom_range(1) ? 21'($urandom_range(16'h0800, 16'hD7FF))
                                  : 21'($urandom_range(16'hE000, 16'hFFFF));
        len = 3;
      end else begin
        point = 21'($urandom_range(SUPP_BASE, CP_MAX));
        len = 4;
      end
      if (len < 4 && $urandom_range(19) == 0)
        len++;
      encode_point(point, len);
    end
    // A sequence cut short by the end of the string.
    if (fault == FAULT_CUT) begin
      len = $urandom_range(2, 4);
      encode_point(21'($urandom_range(SUPP_BASE, CP_MAX)), len);
      repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
    end
    if (fault == FAULT_NOISE) begin
      foreach (str_bytes[i])
        str_bytes[i] = 8'($urandom_range(0, 255));
    end
    foreach (str_bytes[i])
      pending_bytes.insert(pending_bytes.size(),
                           '{byte_in: str_bytes[i],
                             string_end: (i == str_bytes.size() - 1)});
    count = str_bytes.size();
  endtask

  // Queue a directed string given as a list of bytes.
  task automatic add_bytes(input logic [7:0] seq[$]);
    foreach (seq[i])
      pending_bytes.insert(pending_bytes.size(),
                           '{byte_in: seq[i], string_end: (i == seq.size() - 1)});
  endtask

  // Wait until every byte is taken and every expected unit has come back.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || utf8_valid || expected_units.size() != 0)
      @(negedge clk);
  endtask

  // One random phase with the given idle rates on both sides.
  task automatic run_phase(input int items, input int in_pct, input int out_pct);
    int queued;
    int n;
    @(negedge clk);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    queued = 0;
    while (queued < items) begin
      add_string(n);
      queued += n;
    end
    wait_drained();
  endtask

  // Report one field that differs from its prediction.
  function automatic void check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      errors++;
    end
  endfunction

  // Input driver: offers the next byte beat once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      utf8_valid <= 1'b0;
    end else begin
      if (utf8_valid && utf8_ready)
        transcode_byte(utf8_beat);
      if (!utf8_valid || utf8_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          utf8_valid <= 1'b1;
          utf8_beat <= pending_bytes.pop_front();
        end else begin
          utf8_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each accepted beat and drives ready, with one long hold.
  always @(posedge clk) begin
    utf16_beat_t want;
    if (rst) begin
      utf16_ready <= 1'b0;
    end else begin
      if (utf16_valid && utf16_ready) begin
        units_seen++;
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, utf16_beat);
          errors++;
        end else begin
          want = expected_units.pop_front();
          check_field("code_unit", want.code_unit, utf16_beat.code_unit);
          check_field("has_unit", want.has_unit, utf16_beat.has_unit);
          check_field("bad_input", want.bad_input, utf16_beat.bad_input);
          check_field("end_of_string", want.end_of_string, utf16_beat.end_of_string);
          check_field("last", want.last, utf16_beat.last);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        utf16_ready <= 1'b0;
      end else if (!held && units_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        utf16_ready <= 1'b0;
      end else begin
        utf16_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: field extremes, a full-range pair, and each error kind.
    @(negedge clk);
    add_bytes('{8'h00, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F});
    add_bytes('{8'h80, 8'h41});              // stray byte, then a dropped end
    add_bytes('{8'hFF});                     // invalid lead on the last byte
    add_bytes('{8'hC3, 8'h41});              // bad continuation
    add_bytes('{8'hED, 8'hA0, 8'h80});       // surrogate value
    add_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hE2}); // too large, then dropped end
    add_bytes('{8'hE2, 8'h82});              // ends inside a sequence
    wait_drained();

    // Random strings: idling, then a stretch without idling, then idling again.
    run_phase(150, 32, 32);
    run_phase(130, 0, 0);
    run_phase(120, 32, 32);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
